@@ rtl/alscf_pkg.sv @@
// Shared types, codes and constants for the slave link connection state machine.
package alscf_pkg;

   // Field widths
   localparam int unsigned MAC_W   = 48;
   localparam int unsigned REG_W   = 16;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;

   // Decoupling queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Heartbeat period used when the register holds zero
   localparam logic [REG_W-1:0] DEFAULT_BEAT = REG_W'(8000);

   // Register reset values
   localparam logic [REG_W-1:0] RST_FLOOD_BURST   = REG_W'(64);
   localparam logic [REG_W-1:0] RST_JOIN_RETRY    = REG_W'(100);
   localparam logic [REG_W-1:0] RST_ACK_WINDOW    = REG_W'(100);
   localparam logic [REG_W-1:0] RST_MUTE_DWELL    = REG_W'(100);
   localparam logic [REG_W-1:0] RST_PEER_ALIVE    = REG_W'(8000);
   localparam logic [REG_W-1:0] RST_HB_PERIOD     = REG_W'(8000);

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOD_BURST = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_JOIN_RETRY  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_WINDOW  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE_DWELL  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_ALIVE  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_HB_PERIOD   = CSR_IDX_W'(5);

   // Received frame kinds
   localparam logic [KIND_W-1:0] KIND_HB      = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_ANN     = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_SCENE   = KIND_W'(3);
   localparam logic [KIND_W-1:0] KIND_GRANT   = KIND_W'(4);
   localparam logic [KIND_W-1:0] KIND_HEADAMP = KIND_W'(5);

   typedef enum logic [1:0] {
      EV_DOWN = 2'd0,
      EV_UP   = 2'd1,
      EV_TICK = 2'd2,
      EV_RX   = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      ST_PHY_DOWN = 3'd0,
      ST_FLOOD    = 3'd1,
      ST_COLD     = 3'd2,
      ST_MUTE     = 3'd3,
      ST_EST      = 3'd4,
      ST_DROP     = 3'd5
   } state_type;

   typedef enum logic [2:0] {
      ACT_STOP    = 3'd0,
      ACT_FLOOD   = 3'd1,
      ACT_COLD    = 3'd2,
      ACT_SILENCE = 3'd3,
      ACT_AUDIO   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      DROP_NONE = 2'd0,
      DROP_MAC  = 2'd1,
      DROP_PEER = 2'd2
   } drop_type;

   // Classified event as it travels through the queue
   typedef struct packed {
      event_type        ev;
      logic             rx;
      logic             is_master;
      logic             is_grant;
      logic             is_hb_ann;
      logic [MAC_W-1:0] src;
   } item_type;

endpackage

@@ rtl/alscf_front.sv @@
// Front end: accepts request beats and classifies each event for the back end.
module alscf_front
   import alscf_pkg::*;
(
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic              req_frame_present,
   input  logic [KIND_W-1:0] req_frame_kind,
   input  logic [MAC_W-1:0]  req_source_mac,
   input  logic              q_full,
   output logic              q_push,
   output item_type          q_item
);

   // Stall while the queue has no room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Decode event and frame kind
   always_comb begin
      q_item.ev        = event_type'(req_type);
      q_item.rx        = (event_type'(req_type) == EV_RX) && req_frame_present;
      q_item.is_master = (req_frame_kind == KIND_HB)    || (req_frame_kind == KIND_ANN)   ||
                         (req_frame_kind == KIND_SCENE) || (req_frame_kind == KIND_GRANT) ||
                         (req_frame_kind == KIND_HEADAMP);
      q_item.is_grant  = (req_frame_kind == KIND_GRANT);
      q_item.is_hb_ann = (req_frame_kind == KIND_HB) || (req_frame_kind == KIND_ANN);
      q_item.src       = req_source_mac;
   end

endmodule

@@ rtl/alscf_queue.sv @@
// Short queue of classified events between the front and back ends.
module alscf_queue
   import alscf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/alscf_back.sv @@
// Back end: link state machine, timers, configuration registers and result register.
module alscf_back
   import alscf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data,
   input  logic                 q_valid,
   input  item_type             q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_action,
   output logic [2:0]           rsp_link_state,
   output logic                 rsp_send_heartbeat,
   output logic                 rsp_send_join,
   output logic [1:0]           rsp_drop_cause,
   output logic [COUNT_W-1:0]   rsp_frame_count
);

   // Configuration registers
   logic [REG_W-1:0] flood_burst_ff, join_retry_ff, ack_len_ff;
   logic [REG_W-1:0] mute_dwell_ff, peer_alive_ff, hb_period_ff;

   // Link state
   state_type          mode_ff, mode_in;
   logic [MAC_W-1:0]   master_ff, master_in;
   logic               known_ff, known_in;
   logic [REG_W-1:0]   flood_sent_ff, flood_sent_in;
   logic [REG_W-1:0]   join_cd_ff, join_cd_in;
   logic [REG_W-1:0]   ack_ff, ack_in;
   logic [REG_W-1:0]   dwell_ff, dwell_in;
   logic [REG_W-1:0]   alive_ff, alive_in;
   logic [REG_W-1:0]   beat_ff, beat_in;
   logic [COUNT_W-1:0] period_ff, period_in;
   drop_type           last_drop_ff, last_drop_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   action_type         act_ff, act_in;
   state_type          shown_ff, shown_in;
   logic               hb_ff, hb_in;
   logic               join_ff, join_in;

   // Shared decisions
   logic               advance;
   logic               learn, known_upd;
   logic [REG_W-1:0]   ack_loaded, ack_dec;
   logic               cold_to_mute;
   logic               join_fire;
   logic [REG_W-1:0]   flood_sent_inc, flood_first;
   logic               flood_done;
   logic [REG_W-1:0]   beat_p;
   logic [REG_W:0]     beat_inc;
   logic               beat_fire;
   logic [REG_W-1:0]   beat_adv;
   logic               mac_change;
   logic               mute_count;
   logic               dwell_end, alive_end;
   logic [COUNT_W-1:0] period_inc;

   // Pop an event when the result register is free or being drained
   assign advance = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop   = advance;

   always_comb begin
      learn          = q_item.rx && q_item.is_master;
      known_upd      = known_ff || learn;
      ack_loaded     = (q_item.rx && q_item.is_grant && (ack_ff == '0)) ? ack_len_ff : ack_ff;
      ack_dec        = ack_loaded - 1'b1;
      cold_to_mute   = (ack_loaded != '0) && (ack_dec == '0);
      join_fire      = (join_cd_ff <= REG_W'(1));
      flood_sent_inc = (flood_sent_ff < flood_burst_ff) ? flood_sent_ff + 1'b1 : flood_sent_ff;
      flood_first    = (flood_burst_ff != '0) ? REG_W'(1) : '0;
      flood_done     = (flood_sent_inc >= flood_burst_ff) && known_upd;
      beat_p         = (hb_period_ff == '0) ? DEFAULT_BEAT : hb_period_ff;
      beat_inc       = {1'b0, beat_ff} + 1'b1;
      beat_fire      = (beat_inc >= {1'b0, beat_p});
      beat_adv       = beat_fire ? '0 : beat_inc[REG_W-1:0];
      mac_change     = q_item.rx && known_ff && (q_item.src != master_ff) && q_item.is_master;
      mute_count     = (q_item.ev == EV_TICK) || (q_item.ev == EV_RX);
      dwell_end      = (dwell_ff <= REG_W'(1));
      alive_end      = (alive_ff <= REG_W'(1));
      period_inc     = period_ff + 1'b1;
   end

   // Next link state
   always_comb begin
      mode_in = mode_ff;
      if (q_item.ev == EV_DOWN) begin
         mode_in = ST_PHY_DOWN;
      end else begin
         unique case (mode_ff)
            ST_PHY_DOWN: begin
               if (q_item.ev == EV_UP) mode_in = ST_FLOOD;
            end
            ST_FLOOD: begin
               if ((q_item.rx && q_item.is_grant) || flood_done) mode_in = ST_COLD;
            end
            ST_COLD: begin
               if (!known_upd) begin
                  mode_in = ST_FLOOD;
               end else if (cold_to_mute) begin
                  mode_in = ST_MUTE;
               end
            end
            ST_MUTE: begin
               if (mute_count && dwell_end) mode_in = ST_EST;
            end
            ST_EST: begin
               if (mac_change || (!q_item.rx && alive_end)) mode_in = ST_DROP;
            end
            ST_DROP: begin
               mode_in = ST_FLOOD;
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // Actions, timers and result fields
   always_comb begin
      master_in     = master_ff;
      known_in      = known_ff;
      flood_sent_in = flood_sent_ff;
      join_cd_in    = join_cd_ff;
      ack_in        = ack_ff;
      dwell_in      = dwell_ff;
      alive_in      = alive_ff;
      beat_in       = beat_ff;
      period_in     = period_ff;
      last_drop_in  = last_drop_ff;
      act_in        = ACT_STOP;
      shown_in      = mode_in;
      hb_in         = 1'b0;
      join_in       = 1'b0;
      if (q_item.ev == EV_DOWN) begin
         known_in = 1'b0;
      end else begin
         unique case (mode_ff)
            ST_PHY_DOWN: begin
               if (q_item.ev == EV_UP) begin
                  flood_sent_in = flood_first;
                  ack_in        = '0;
                  period_in     = COUNT_W'(1);
                  act_in        = ACT_FLOOD;
               end
            end
            ST_FLOOD: begin
               if (learn) begin
                  master_in = q_item.src;
                  known_in  = 1'b1;
               end
               period_in = period_inc;
               if (q_item.rx && q_item.is_grant) begin
                  // early grant: straight to cold-connect with a join
                  join_in    = 1'b1;
                  join_cd_in = join_retry_ff;
                  act_in     = ACT_COLD;
               end else begin
                  flood_sent_in = flood_sent_inc;
                  act_in        = ACT_FLOOD;
                  shown_in      = ST_FLOOD;
                  if (flood_done) join_cd_in = '0;
               end
            end
            ST_COLD: begin
               if (learn) begin
                  master_in = q_item.src;
                  known_in  = 1'b1;
               end
               ack_in = ack_loaded;
               if (!known_upd) begin
                  // master lost: restart the flood burst
                  flood_sent_in = flood_first;
                  ack_in        = '0;
                  period_in     = period_inc;
                  act_in        = ACT_FLOOD;
               end else if (cold_to_mute) begin
                  ack_in   = '0;
                  dwell_in = mute_dwell_ff;
                  alive_in = peer_alive_ff;
                  act_in   = ACT_SILENCE;
               end else begin
                  if (ack_loaded != '0) ack_in = ack_dec;
                  period_in = period_inc;
                  act_in    = ACT_COLD;
                  if (join_fire) begin
                     join_in    = 1'b1;
                     join_cd_in = join_retry_ff;
                  end else begin
                     join_cd_in = join_cd_ff - 1'b1;
                  end
               end
            end
            ST_MUTE: begin
               act_in = ACT_SILENCE;
               if (mute_count) begin
                  period_in = period_inc;
                  if (dwell_end) begin
                     dwell_in = '0;
                     alive_in = peer_alive_ff;
                     beat_in  = '0;
                     act_in   = ACT_AUDIO;
                  end else begin
                     dwell_in = dwell_ff - 1'b1;
                  end
               end
            end
            ST_EST: begin
               if (q_item.rx) begin
                  if (mac_change) begin
                     last_drop_in = DROP_MAC;
                     act_in       = ACT_STOP;
                  end else begin
                     if (q_item.is_hb_ann) alive_in = peer_alive_ff;
                     beat_in = beat_adv;
                     hb_in   = beat_fire;
                     act_in  = ACT_AUDIO;
                  end
               end else begin
                  period_in = period_inc;
                  if (alive_end) begin
                     alive_in     = '0;
                     last_drop_in = DROP_PEER;
                     act_in       = ACT_STOP;
                  end else begin
                     alive_in = alive_ff - 1'b1;
                     beat_in  = beat_adv;
                     hb_in    = beat_fire;
                     act_in   = ACT_AUDIO;
                  end
               end
            end
            ST_DROP: begin
               known_in      = 1'b0;
               flood_sent_in = flood_first;
               ack_in        = '0;
               period_in     = period_inc;
               act_in        = ACT_FLOOD;
            end
            default: act_in = ACT_STOP;
         endcase
      end
   end

   // Hold the result until it is taken
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flood_burst_ff <= RST_FLOOD_BURST;
         join_retry_ff  <= RST_JOIN_RETRY;
         ack_len_ff     <= RST_ACK_WINDOW;
         mute_dwell_ff  <= RST_MUTE_DWELL;
         peer_alive_ff  <= RST_PEER_ALIVE;
         hb_period_ff   <= RST_HB_PERIOD;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FLOOD_BURST: flood_burst_ff <= csr_data;
            CSR_JOIN_RETRY:  join_retry_ff  <= csr_data;
            CSR_ACK_WINDOW:  ack_len_ff     <= csr_data;
            CSR_MUTE_DWELL:  mute_dwell_ff  <= csr_data;
            CSR_PEER_ALIVE:  peer_alive_ff  <= csr_data;
            CSR_HB_PERIOD:   hb_period_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance link state on each popped event
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ST_PHY_DOWN;
         master_ff     <= '0;
         known_ff      <= 1'b0;
         flood_sent_ff <= '0;
         join_cd_ff    <= '0;
         ack_ff        <= '0;
         dwell_ff      <= '0;
         alive_ff      <= '0;
         beat_ff       <= '0;
         period_ff     <= '0;
         last_drop_ff  <= DROP_NONE;
      end else if (advance) begin
         mode_ff       <= mode_in;
         master_ff     <= master_in;
         known_ff      <= known_in;
         flood_sent_ff <= flood_sent_in;
         join_cd_ff    <= join_cd_in;
         ack_ff        <= ack_in;
         dwell_ff      <= dwell_in;
         alive_ff      <= alive_in;
         beat_ff       <= beat_in;
         period_ff     <= period_in;
         last_drop_ff  <= last_drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         act_ff   <= act_in;
         shown_ff <= shown_in;
         hb_ff    <= hb_in;
         join_ff  <= join_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = act_ff;
   assign rsp_link_state     = shown_ff;
   assign rsp_send_heartbeat = hb_ff;
   assign rsp_send_join      = join_ff;
   assign rsp_drop_cause     = last_drop_ff;
   assign rsp_frame_count    = period_ff;

endmodule

@@ rtl/audio_link_slave_connection_fsm.sv @@
// A result beat is offered once its accepted request beat has passed through the queue
// (the event is held in the queue register and then enters the result register).
// Throughput: one event per cycle while rsp_stall is low; the state machine retires one event
// per cycle when the result side does not stall, and the two-entry queue absorbs result-side stalls.
// Reset: synchronous; link state goes to phy_down, all counters and the drop cause
// clear, and the configuration registers return to their default values.
module audio_link_slave_connection_fsm
   import alscf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic                 req_frame_present,
   input  logic [KIND_W-1:0]    req_frame_kind,
   input  logic [MAC_W-1:0]     req_source_mac,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_action,
   output logic [2:0]           rsp_link_state,
   output logic                 rsp_send_heartbeat,
   output logic                 rsp_send_join,
   output logic [1:0]           rsp_drop_cause,
   output logic [COUNT_W-1:0]   rsp_frame_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data
);

   logic     q_full, q_push, q_pop, q_valid;
   item_type push_item, head_item;

   // Registers are always writable
   assign csr_ready = 1'b1;

   alscf_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_frame_present (req_frame_present),
      .req_frame_kind    (req_frame_kind),
      .req_source_mac    (req_source_mac),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (push_item)
   );

   alscf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   alscf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .q_valid            (q_valid),
      .q_item             (head_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_action         (rsp_action),
      .rsp_link_state     (rsp_link_state),
      .rsp_send_heartbeat (rsp_send_heartbeat),
      .rsp_send_join      (rsp_send_join),
      .rsp_drop_cause     (rsp_drop_cause),
      .rsp_frame_count    (rsp_frame_count)
   );

endmodule
